/* rtl/core/baro_second_order_compensation_assert.svh */
// Assertion macros for the barometer compensation core.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef BARO_SECOND_ORDER_COMPENSATION_ASSERT_SVH
`define BARO_SECOND_ORDER_COMPENSATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSOC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BSOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bsoc_pkg.sv */
// Package for the barometer second-order compensation core.
// Field widths, pipeline depth and calibration register indexes; no dependencies.
`timescale 1ns / 1ps

package bsoc_pkg;

    // Port field widths
    localparam int RawW  = 24;
    localparam int CalW  = 16;
    localparam int TempW = 19;
    localparam int PresW = 32;
    localparam int IdxW  = 3;

    // Register stages from accepted start to the result strobe
    localparam int Latency = 11;

    // Calibration register indexes
    typedef enum logic [IdxW-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

endpackage

/* rtl/core/baro_second_order_compensation.sv */
// Barometer second-order temperature/pressure compensation, 11-stage pipeline.
// Depends on bsoc_pkg and baro_second_order_compensation_assert.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  sample   | start in, busy out      | i_raw_pressure, i_raw_temperature
//  result   | o_strobe out            | o_temp_centi_deg, o_pressure_centi_hpa
//  config   | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// One sample pair per cycle; each result leaves stage 11 together with its o_strobe.
// Depth is set by the chain of multiplies: dT products, squares for the
// cold-range terms, then D1*SENS as two partial products on SENS[19:0] and SENS[40:20].
// busy never rises, and the result side has no backpressure.
// Synchronous reset clears the stage valid bits and the calibration words.
`timescale 1ns / 1ps
`include "baro_second_order_compensation_assert.svh"

module baro_second_order_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                start,
    output logic                                busy,
    input  logic [bsoc_pkg::RawW-1:0]           i_raw_pressure,
    input  logic [bsoc_pkg::RawW-1:0]           i_raw_temperature,
    // result channel
    output logic                                o_strobe,
    output logic signed [bsoc_pkg::TempW-1:0]   o_temp_centi_deg,
    output logic signed [bsoc_pkg::PresW-1:0]   o_pressure_centi_hpa,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsoc_pkg::IdxW-1:0]           i_cfg_index,
    input  logic [bsoc_pkg::CalW-1:0]           i_cfg_data
);

    // ---------------- control state ----------------
    logic [bsoc_pkg::Latency-1:0] r_vld;
    logic [bsoc_pkg::CalW-1:0]    r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic                         n_accept;

    // ---------------- payload stages ----------------
    // stage 1
    logic [23:0]        r_d1_1;
    logic signed [24:0] r_dt_1;
    logic signed [24:0] n_dt;
    // stage 2
    logic [23:0]        r_d1_2;
    logic signed [41:0] r_p6_2, r_p4_2, r_p3_2;
    logic [47:0]        r_pdd_2;
    logic signed [41:0] n_p6, n_p4, n_p3;
    logic signed [49:0] n_sq;
    // stage 3
    logic [23:0]        r_d1_3;
    logic signed [18:0] r_tq_3;
    logic signed [19:0] r_temp_3, r_cd_3;
    logic signed [40:0] r_off_3, r_sens_3;
    logic [16:0]        r_t2_3;
    logic signed [41:0] n_q6, n_q4, n_q3;
    logic signed [18:0] n_tq;
    // stage 4
    logic [23:0]        r_d1_4;
    logic signed [19:0] r_temp_4;
    logic signed [40:0] r_off_4, r_sens_4;
    logic [16:0]        r_t2_4;
    logic [35:0]        r_dl2_4, r_cd2_4;
    logic               r_lt2000_4, r_lt1500_4;
    logic signed [37:0] n_dl2;
    logic signed [39:0] n_cd2;
    // stage 5
    logic [23:0]        r_d1_5;
    logic signed [19:0] r_temp_5;
    logic signed [40:0] r_off_5, r_sens_5;
    logic [16:0]        r_t2_5;
    logic [39:0]        r_off2_5, r_sens2_5;
    logic [38:0]        n_dl5, n_cd7, n_cd11;
    logic [39:0]        n_off2, n_sens2;
    // stage 6
    logic [23:0]        r_d1_6;
    logic signed [19:0] r_temp_6;
    logic signed [40:0] r_off_6, r_sens_6;
    // stage 7
    logic signed [19:0] r_temp_7;
    logic signed [40:0] r_off_7;
    logic [43:0]        r_pp_lo_7;
    logic signed [44:0] r_pp_hi_7;
    logic signed [45:0] n_pp_hi;
    // stage 8
    logic signed [19:0] r_temp_8;
    logic signed [40:0] r_off_8;
    logic signed [64:0] r_prod_8;
    // stage 9
    logic signed [19:0] r_temp_9;
    logic signed [40:0] r_off_9;
    logic signed [43:0] r_q_9;
    logic signed [64:0] n_qp;
    // stage 10
    logic signed [19:0] r_temp_10;
    logic signed [44:0] r_diff_10;
    // stage 11 (output)
    logic signed [18:0] r_temp_out;
    logic signed [31:0] r_pres_out;
    logic signed [44:0] n_pq;

    // Pipeline takes a transaction every cycle
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    // ---------------- valid bits and calibration words ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_c5  <= '0;
            r_c6  <= '0;
        end else begin
            r_vld <= {r_vld[bsoc_pkg::Latency-2:0], n_accept};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bsoc_pkg::CFG_C1: r_c1 <= i_cfg_data;
                    bsoc_pkg::CFG_C2: r_c2 <= i_cfg_data;
                    bsoc_pkg::CFG_C3: r_c3 <= i_cfg_data;
                    bsoc_pkg::CFG_C4: r_c4 <= i_cfg_data;
                    bsoc_pkg::CFG_C5: r_c5 <= i_cfg_data;
                    bsoc_pkg::CFG_C6: r_c6 <= i_cfg_data;
                    default: ;  // unused index, write dropped
                endcase
            end
        end
    end

    // ---------------- datapath combinational terms ----------------
    // dT = D2 - C5 * 2^8
    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'b0});

    // dT products
    assign n_p6 = r_dt_1 * $signed({1'b0, r_c6});
    assign n_p4 = r_dt_1 * $signed({1'b0, r_c4});
    assign n_p3 = r_dt_1 * $signed({1'b0, r_c3});
    assign n_sq = r_dt_1 * r_dt_1;

    // first-order scaling, divides truncate toward zero
    assign n_q6 = r_p6_2 / 42'sd8388608;
    assign n_q4 = r_p4_2 / 42'sd64;
    assign n_q3 = r_p3_2 / 42'sd128;
    assign n_tq = n_q6[18:0];

    // squares for the cold-range terms (dl = TEMP - 2000 = tq, cd = TEMP + 1500)
    assign n_dl2 = r_tq_3 * r_tq_3;
    assign n_cd2 = r_cd_3 * r_cd_3;

    // OFF2 / SENS2 by shift-add; all terms are non-negative
    assign n_dl5  = {1'b0, r_dl2_4, 2'b0} + {3'b0, r_dl2_4};
    assign n_cd7  = {r_cd2_4, 3'b0} - {3'b0, r_cd2_4};
    assign n_cd11 = {r_cd2_4, 3'b0} + {2'b0, r_cd2_4, 1'b0} + {3'b0, r_cd2_4};

    always_comb begin
        n_off2  = {2'b0, n_dl5[38:1]};
        n_sens2 = {3'b0, n_dl5[38:2]};
        if (r_lt1500_4) begin
            n_off2  = n_off2 + {1'b0, n_cd7};
            n_sens2 = n_sens2 + {2'b0, n_cd11[38:1]};
        end
        if (!r_lt2000_4) begin
            n_off2  = '0;
            n_sens2 = '0;
        end
    end

    // D1 * SENS high partial product
    assign n_pp_hi = $signed({1'b0, r_d1_6}) * $signed(r_sens_6[40:20]);

    // final scaling
    assign n_qp = r_prod_8 / 65'sd2097152;
    assign n_pq = r_diff_10 / 45'sd32768;

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        // stage 1
        r_d1_1 <= i_raw_pressure;
        r_dt_1 <= n_dt;
        // stage 2
        r_d1_2  <= r_d1_1;
        r_p6_2  <= n_p6;
        r_p4_2  <= n_p4;
        r_p3_2  <= n_p3;
        r_pdd_2 <= n_sq[47:0];
        // stage 3
        r_d1_3   <= r_d1_2;
        r_tq_3   <= n_tq;
        r_temp_3 <= 20'(n_tq) + 20'sd2000;
        r_cd_3   <= 20'(n_tq) + 20'sd3500;
        r_off_3  <= $signed({8'b0, r_c2, 17'b0}) + n_q4[40:0];
        r_sens_3 <= $signed({9'b0, r_c1, 16'b0}) + n_q3[40:0];
        r_t2_3   <= r_pdd_2[47:31];
        // stage 4
        r_d1_4     <= r_d1_3;
        r_temp_4   <= r_temp_3;
        r_off_4    <= r_off_3;
        r_sens_4   <= r_sens_3;
        r_t2_4     <= r_t2_3;
        r_dl2_4    <= n_dl2[35:0];
        r_cd2_4    <= n_cd2[35:0];
        r_lt2000_4 <= r_tq_3[18];
        r_lt1500_4 <= (r_tq_3 < -19'sd3500);
        // stage 5
        r_d1_5    <= r_d1_4;
        r_temp_5  <= r_temp_4;
        r_off_5   <= r_off_4;
        r_sens_5  <= r_sens_4;
        r_t2_5    <= r_lt2000_4 ? r_t2_4 : '0;
        r_off2_5  <= n_off2;
        r_sens2_5 <= n_sens2;
        // stage 6: apply second-order corrections
        r_d1_6   <= r_d1_5;
        r_temp_6 <= r_temp_5 - $signed({3'b0, r_t2_5});
        r_off_6  <= r_off_5 - $signed({1'b0, r_off2_5});
        r_sens_6 <= r_sens_5 - $signed({1'b0, r_sens2_5});
        // stage 7: split D1 * SENS
        r_temp_7  <= r_temp_6;
        r_off_7   <= r_off_6;
        r_pp_lo_7 <= r_d1_6 * r_sens_6[19:0];
        r_pp_hi_7 <= n_pp_hi[44:0];
        // stage 8: recombine
        r_temp_8 <= r_temp_7;
        r_off_8  <= r_off_7;
        r_prod_8 <= (65'(r_pp_hi_7) <<< 20) + $signed({21'b0, r_pp_lo_7});
        // stage 9
        r_temp_9 <= r_temp_8;
        r_off_9  <= r_off_8;
        r_q_9    <= n_qp[43:0];
        // stage 10
        r_temp_10 <= r_temp_9;
        r_diff_10 <= 45'(r_q_9) - 45'(r_off_9);
        // stage 11
        r_temp_out <= r_temp_10[18:0];
        r_pres_out <= n_pq[31:0];
    end

    assign o_strobe             = r_vld[bsoc_pkg::Latency-1];
    assign o_temp_centi_deg     = r_temp_out;
    assign o_pressure_centi_hpa = r_pres_out;

    // ---------------- assertions ----------------
    `BSOC_ASSERT_IMPL(a_strobe_latency, o_strobe, $past(n_accept, bsoc_pkg::Latency), "result without matching start")
    `BSOC_ASSERT_IMPL(a_cold_nesting, r_vld[3] && r_lt1500_4, r_lt2000_4, "below -15C flagged but not below 20C")
    `BSOC_ASSERT_NEXT(a_warm_no_corr, r_vld[3] && !r_lt2000_4, r_off2_5 == '0 && r_sens2_5 == '0 && r_t2_5 == '0, "second-order terms nonzero above 20C")

endmodule
